// File: rtl/core/mar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mar_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int MAX_INNER_DEF  = 256;

    localparam int ELEM_W     = 32;
    localparam int RESULT_W   = 32;
    localparam int COL_W      = 8;
    localparam int OP_W       = 3;
    localparam int COUNT_W    = 16;
    localparam int INNER_CW   = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_OP_SELECT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IS_SIGNED    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REDUCE_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_COUNT  = 3'd4;

    localparam logic [OP_W-1:0] OP_SUM  = 3'd0;
    localparam logic [OP_W-1:0] OP_MAX  = 3'd1;
    localparam logic [OP_W-1:0] OP_MIN  = 3'd2;
    localparam logic [OP_W-1:0] OP_PROD = 3'd3;
    localparam logic [OP_W-1:0] OP_XOR  = 3'd4;
    localparam logic [OP_W-1:0] OP_OR   = 3'd5;
    localparam logic [OP_W-1:0] OP_AND  = 3'd6;

    typedef struct packed {
        logic first_row;
        logic last_row;
        logic last_beat;
    } seq_info_t;

endpackage

`default_nettype wire

// File: rtl/core/mar_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mar_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/mar_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module mar_seq #(
    parameter int MAX_INNER = mar_pkg::MAX_INNER_DEF,
    localparam int IW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               step,
    input  wire logic [mar_pkg::COUNT_W-1:0]        outer_count,
    input  wire logic [mar_pkg::COUNT_W-1:0]        reduce_count,
    input  wire logic [mar_pkg::INNER_CW-1:0]       inner_count,
    output logic      [IW-1:0]                      col,
    output logic      [mar_pkg::COL_W-1:0]          col_low,
    output mar_pkg::seq_info_t                      info
);

    localparam int CW = (IW + 1 > mar_pkg::INNER_CW + 1) ? IW + 1 : mar_pkg::INNER_CW + 1;

    logic [IW-1:0]               inner_reg, inner_next;
    logic [mar_pkg::COUNT_W-1:0] reduce_reg, reduce_next;
    logic [mar_pkg::COUNT_W-1:0] outer_reg, outer_next;

    logic [CW-1:0]                 n_inner;
    logic [mar_pkg::COUNT_W-1:0]   n_reduce, n_outer;
    logic [CW-1:0]                 inner_ext;
    logic                          last_inner, last_reduce, last_outer;

    always_comb begin
        n_inner = (inner_count == '0) ? CW'(1) : CW'(inner_count);
        if (n_inner > CW'(MAX_INNER)) begin
            n_inner = CW'(MAX_INNER);
        end
        n_reduce = (reduce_count == '0) ? mar_pkg::COUNT_W'(1) : reduce_count;
        n_outer  = (outer_count == '0) ? mar_pkg::COUNT_W'(1) : outer_count;

        inner_ext   = CW'(inner_reg);
        last_inner  = (inner_ext + CW'(1)) >= n_inner;
        last_reduce = ({1'b0, reduce_reg} + 17'd1) >= {1'b0, n_reduce};
        last_outer  = ({1'b0, outer_reg} + 17'd1) >= {1'b0, n_outer};

        inner_next  = inner_reg;
        reduce_next = reduce_reg;
        outer_next  = outer_reg;
        if (last_inner) begin
            inner_next = '0;
            if (last_reduce) begin
                reduce_next = '0;
                outer_next  = last_outer ? '0 : outer_reg + mar_pkg::COUNT_W'(1);
            end else begin
                reduce_next = reduce_reg + mar_pkg::COUNT_W'(1);
            end
        end else begin
            inner_next = inner_reg + IW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inner_reg  <= '0;
            reduce_reg <= '0;
            outer_reg  <= '0;
        end else if (step) begin
            inner_reg  <= inner_next;
            reduce_reg <= reduce_next;
            outer_reg  <= outer_next;
        end
    end

    assign col     = inner_reg;
    assign col_low = inner_ext[mar_pkg::COL_W-1:0];

    assign info.first_row = (reduce_reg == '0);
    assign info.last_row  = last_reduce;
    assign info.last_beat = last_reduce && last_inner && last_outer;

endmodule

`default_nettype wire

// File: rtl/core/mar_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module mar_alu #(
    parameter int DATA_WIDTH = mar_pkg::DATA_WIDTH_DEF
) (
    input  wire logic [mar_pkg::OP_W-1:0] op_select,
    input  wire logic                     is_signed,
    input  wire logic                     first_row,
    input  wire logic [DATA_WIDTH-1:0]    acc,
    input  wire logic [DATA_WIDTH-1:0]    value,
    output logic      [DATA_WIDTH-1:0]    result
);

    logic [DATA_WIDTH-1:0] prod;
    logic [DATA_WIDTH-1:0] acc_key, val_key, flip;
    logic                  val_gt, acc_gt;

    // low half of the product only; wide words split into 32-bit partials
    generate
        if (DATA_WIDTH <= 32) begin : g_mul_narrow
            assign prod = acc * value;
        end else begin : g_mul_wide
            localparam int HW = DATA_WIDTH - 32;
            logic [63:0] p_ll;
            logic [HW-1:0] p_lh, p_hl;
            assign p_ll = {32'd0, acc[31:0]} * {32'd0, value[31:0]};
            assign p_lh = HW'(acc[31:0] * value[DATA_WIDTH-1:32]);
            assign p_hl = HW'(acc[DATA_WIDTH-1:32] * value[31:0]);
            assign prod = DATA_WIDTH'(p_ll) + {p_lh + p_hl, 32'd0};
        end
    endgenerate

    always_comb begin
        flip    = {is_signed, {(DATA_WIDTH-1){1'b0}}};
        acc_key = acc ^ flip;
        val_key = value ^ flip;
        val_gt  = val_key > acc_key;
        acc_gt  = acc_key > val_key;

        case (op_select)
            mar_pkg::OP_MAX:  result = val_gt ? value : acc;
            mar_pkg::OP_MIN:  result = acc_gt ? value : acc;
            mar_pkg::OP_PROD: result = prod;
            mar_pkg::OP_XOR:  result = acc ^ value;
            mar_pkg::OP_OR:   result = acc | value;
            mar_pkg::OP_AND:  result = acc & value;
            default:          result = acc + value;
        endcase

        if (first_row) begin
            result = value;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/middle_axis_reduction_core.sv
// Path: an accepted beat passes the stage 1 registers and, on its last row, the output register to m_.
// Throughput: one element per cycle while s_ready is high; the accumulator RAM is read
//   on accept and written back when stage 1 fires, the previous write forwarded on a same-column hit.
// Reset (aresetn low, synchronous): positions, pipeline and output go empty, registers
//   return to sum, signed, all counts one. The accumulator RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module middle_axis_reduction_core #(
    parameter int DATA_WIDTH = mar_pkg::DATA_WIDTH_DEF,
    parameter int MAX_INNER  = mar_pkg::MAX_INNER_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              cfg_wr_en,
    input  wire logic [mar_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  wire logic [mar_pkg::CFG_DATA_W-1:0]    cfg_wr_data,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [mar_pkg::ELEM_W-1:0]        s_element_value,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [mar_pkg::RESULT_W-1:0]      m_result_value,
    output logic      [mar_pkg::COL_W-1:0]         m_column_index,
    output logic                                   m_is_last
);

    localparam int IW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;

    // configuration
    logic [mar_pkg::OP_W-1:0]     op_reg;
    logic                         signed_reg;
    logic [mar_pkg::COUNT_W-1:0]  outer_reg;
    logic [mar_pkg::COUNT_W-1:0]  reduce_reg;
    logic [mar_pkg::INNER_CW-1:0] inner_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg     <= mar_pkg::OP_SUM;
            signed_reg <= 1'b1;
            outer_reg  <= mar_pkg::COUNT_W'(1);
            reduce_reg <= mar_pkg::COUNT_W'(1);
            inner_reg  <= mar_pkg::INNER_CW'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                mar_pkg::REG_OP_SELECT:    op_reg     <= cfg_wr_data[mar_pkg::OP_W-1:0];
                mar_pkg::REG_IS_SIGNED:    signed_reg <= cfg_wr_data[0];
                mar_pkg::REG_OUTER_COUNT:  outer_reg  <= cfg_wr_data;
                mar_pkg::REG_REDUCE_COUNT: reduce_reg <= cfg_wr_data;
                mar_pkg::REG_INNER_COUNT:  inner_reg  <= cfg_wr_data[mar_pkg::INNER_CW-1:0];
                default: ;
            endcase
        end
    end

    // stage 0: position sequencer and RAM read
    logic                 accept;
    logic [IW-1:0]        seq_col;
    logic [mar_pkg::COL_W-1:0] seq_col_low;
    mar_pkg::seq_info_t   seq_info;

    mar_seq #(
        .MAX_INNER (MAX_INNER)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (accept),
        .outer_count  (outer_reg),
        .reduce_count (reduce_reg),
        .inner_count  (inner_reg),
        .col          (seq_col),
        .col_low      (seq_col_low),
        .info         (seq_info)
    );

    // stage 1 registers
    logic                       s1_valid_reg;
    logic [IW-1:0]              s1_col_reg;
    logic [mar_pkg::COL_W-1:0]  s1_col_low_reg;
    mar_pkg::seq_info_t         s1_info_reg;
    logic [DATA_WIDTH-1:0]      s1_value_reg;
    logic                       fwd_hit_reg;
    logic [DATA_WIDTH-1:0]      fwd_data_reg;

    logic [DATA_WIDTH-1:0]      ram_rd_data;
    logic [DATA_WIDTH-1:0]      acc_in;
    logic [DATA_WIDTH-1:0]      s1_acc;
    logic                       s1_adv;
    logic                       s1_fire;

    logic                          out_valid_reg;
    logic [mar_pkg::RESULT_W-1:0]  out_value_reg;
    logic [mar_pkg::COL_W-1:0]     out_col_reg;
    logic                          out_last_reg;

    assign s1_adv  = !s1_info_reg.last_row || !out_valid_reg || m_ready;
    assign s1_fire = s1_valid_reg && s1_adv;
    assign s_ready = !s1_valid_reg || s1_adv;
    assign accept  = s_valid && s_ready;

    mar_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_INNER)
    ) u_acc_ram (
        .aclk    (aclk),
        .wr_en   (s1_fire),
        .wr_addr (s1_col_reg),
        .wr_data (s1_acc),
        .rd_en   (accept),
        .rd_addr (seq_col),
        .rd_data (ram_rd_data)
    );

    assign acc_in = fwd_hit_reg ? fwd_data_reg : ram_rd_data;

    mar_alu #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_alu (
        .op_select (op_reg),
        .is_signed (signed_reg),
        .first_row (s1_info_reg.first_row),
        .acc       (acc_in),
        .value     (s1_value_reg),
        .result    (s1_acc)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    // write-back of the beat leaving stage 1 lands on the same edge as this read
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_col_reg     <= seq_col;
            s1_col_low_reg <= seq_col_low;
            s1_info_reg    <= seq_info;
            s1_value_reg   <= DATA_WIDTH'(s_element_value);
            fwd_hit_reg    <= s1_valid_reg && (s1_col_reg == seq_col);
            fwd_data_reg   <= s1_acc;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_fire && s1_info_reg.last_row) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && s1_info_reg.last_row) begin
            out_value_reg <= mar_pkg::RESULT_W'(s1_acc);
            out_col_reg   <= s1_col_low_reg;
            out_last_reg  <= s1_info_reg.last_beat;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_result_value = out_value_reg;
    assign m_column_index = out_col_reg;
    assign m_is_last      = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/core/mar_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mar_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [mar_pkg::RESULT_W-1:0]  m_result_value,
    input wire logic [mar_pkg::COL_W-1:0]     m_column_index,
    input wire logic                          m_is_last
);

    // reset empties the pipe and opens the input
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipe not empty after reset");

    // a fresh result must trace back to an input beat accepted earlier
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without matching input beat");

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("m_valid dropped before beat taken");

    a_payload_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_result_value) && $stable(m_column_index)
            && $stable(m_is_last))
        else $error("result payload changed while stalled");

endmodule

bind middle_axis_reduction_core mar_checker u_mar_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_value (m_result_value),
    .m_column_index (m_column_index),
    .m_is_last      (m_is_last)
);

`default_nettype wire
